// File: rtl/core/dqb_pkg.sv
`default_nettype none
// ============================================================================
// dqb_pkg: shared types and constants of the DNS query builder
// Command queue entry, byte push bundle, output word, header table.
// ============================================================================
package dqb_pkg;

    localparam int MAX_LABEL = 63;
    localparam int FILL_W    = 6;           // holds 0..MAX_LABEL
    localparam int HDR_LEN   = 12;
    localparam int CNT_W     = 4;           // header and trailer byte counter
    localparam int TRL_LEN   = 5;
    localparam int TRL_QTYPE = 2;           // trailer position of query type
    localparam int TRL_CLASS = 4;           // trailer position of class low byte
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;
    localparam int ADDR_W    = 3;

    localparam logic [7:0] DOT_CHAR   = 8'h2E;
    localparam logic [7:0] CLASS_IN   = 8'h01;
    localparam logic [7:0] QTYPE_RST  = 8'h01;
    localparam logic [0:0] REG_QTYPE  = 1'b0;

    typedef enum logic [1:0] {
        OP_STORE     = 2'd0,
        OP_STORE_END = 2'd1,
        OP_FLUSH     = 2'd2,
        OP_ERROR     = 2'd3
    } t_op;

    typedef struct packed {
        logic       hdr;
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic       vld;
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_push;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic       sv;
        logic       last;
        logic       bad;
    } t_word;

    function automatic logic [7:0] hdr_byte(input logic [CNT_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h63;
            4'd1:    b = 8'h65;
            4'd2:    b = 8'h01;
            4'd5:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/dqb_front.sv
`default_nettype none
// ============================================================================
// dqb_front: name byte classifier
// Tracks label length, header, skip state; turns unskipped bytes into commands.
// ============================================================================
module dqb_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_final,
    output logic               o_ready,
    input  wire logic          i_full,
    output logic               o_push,
    output dqb_pkg::t_cmd      o_cmd
);
    import dqb_pkg::*;

    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_hdr_sent, n_hdr_sent;
    logic              r_skip, n_skip;
    logic              acc;

    assign o_ready = !i_full;
    assign acc     = i_valid && !i_full;

    always_comb begin
        n_fill     = r_fill;
        n_hdr_sent = r_hdr_sent;
        n_skip     = r_skip;
        o_push     = 1'b0;
        o_cmd.hdr  = !r_hdr_sent;
        o_cmd.op   = OP_STORE;
        o_cmd.data = i_byte;
        if (acc) begin
            if (r_skip) begin
                // drop the rest of a bad name
                if (i_final) begin
                    n_skip = 1'b0;
                end
            end else begin
                o_push     = 1'b1;
                n_hdr_sent = 1'b1;
                if ((i_byte == DOT_CHAR && (i_final || r_fill == '0)) ||
                    (i_byte != DOT_CHAR && r_fill == FILL_W'(MAX_LABEL))) begin
                    o_cmd.op   = OP_ERROR;
                    n_fill     = '0;
                    n_hdr_sent = 1'b0;
                    n_skip     = !i_final;
                end else if (i_byte == DOT_CHAR) begin
                    o_cmd.op = OP_FLUSH;
                    n_fill   = '0;
                end else if (i_final) begin
                    o_cmd.op   = OP_STORE_END;
                    n_fill     = '0;
                    n_hdr_sent = 1'b0;
                end else begin
                    o_cmd.op = OP_STORE;
                    n_fill   = r_fill + FILL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_hdr_sent <= 1'b0;
            r_skip     <= 1'b0;
        end else begin
            r_fill     <= n_fill;
            r_hdr_sent <= n_hdr_sent;
            r_skip     <= n_skip;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/dqb_fifo.sv
`default_nettype none
// ============================================================================
// dqb_fifo: command queue
// Short queue that decouples the classifier from the packet sequencer.
// ============================================================================
module dqb_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire dqb_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output dqb_pkg::t_cmd      o_cmd,
    output logic               o_empty
);
    import dqb_pkg::*;

    t_cmd              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wptr, r_rptr;
    logic [Q_AW:0]     r_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (Q_AW+1)'(1);
                2'b01:   r_count <= r_count - (Q_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("command queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("command queue underflow");

endmodule
`default_nettype wire

// File: rtl/core/dqb_back.sv
`default_nettype none
// ============================================================================
// dqb_back: packet sequencer
// Holds label bytes and plays header, labels, trailer and errors as bytes.
// ============================================================================
module dqb_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    output logic               o_pop,
    input  wire dqb_pkg::t_cmd i_cmd,
    input  wire logic [7:0]    i_qtype,
    output dqb_pkg::t_push     o_push,
    input  wire logic          i_push_rdy
);
    import dqb_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b000_0001,
        S_HDR  = 7'b000_0010,
        S_EXEC = 7'b000_0100,
        S_LEN  = 7'b000_1000,
        S_BODY = 7'b001_0000,
        S_TRL  = 7'b010_0000,
        S_ERR  = 7'b100_0000
    } t_state;

    t_state            r_state, n_state;
    t_cmd              r_cmd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [FILL_W-1:0] r_idx, n_idx;
    logic              r_end, n_end;
    logic [7:0]        r_mem [MAX_LABEL];
    logic [7:0]        r_rd_data;
    logic              mem_we, rd_en;
    logic [FILL_W-1:0] rd_addr;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_fill  = r_fill;
        n_idx   = r_idx;
        n_end   = r_end;
        o_pop   = 1'b0;
        o_push  = '0;
        mem_we  = 1'b0;
        rd_en   = 1'b0;
        rd_addr = r_idx;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_cnt   = '0;
                    n_state = i_cmd.hdr ? S_HDR : S_EXEC;
                end
            end
            S_HDR: begin
                o_push.vld  = 1'b1;
                o_push.data = hdr_byte(r_cnt);
                if (i_push_rdy) begin
                    if (r_cnt == CNT_W'(HDR_LEN - 1)) begin
                        n_state = S_EXEC;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            S_EXEC: begin
                case (r_cmd.op)
                    OP_STORE: begin
                        mem_we  = 1'b1;
                        n_fill  = r_fill + FILL_W'(1);
                        n_state = S_IDLE;
                    end
                    OP_STORE_END: begin
                        mem_we  = 1'b1;
                        n_fill  = r_fill + FILL_W'(1);
                        n_end   = 1'b1;
                        n_state = S_LEN;
                    end
                    OP_FLUSH: begin
                        n_end   = 1'b0;
                        n_state = S_LEN;
                    end
                    OP_ERROR: begin
                        n_state = S_ERR;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_LEN: begin
                o_push.vld  = 1'b1;
                o_push.data = {{(8 - FILL_W){1'b0}}, r_fill};
                if (i_push_rdy) begin
                    if (r_fill == '0) begin
                        n_fill  = '0;
                        n_cnt   = '0;
                        n_state = r_end ? S_TRL : S_IDLE;
                    end else begin
                        // fetch the first stored byte
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_idx   = '0;
                        n_state = S_BODY;
                    end
                end
            end
            S_BODY: begin
                o_push.vld  = 1'b1;
                o_push.data = r_rd_data;
                if (i_push_rdy) begin
                    if (r_idx == r_fill - FILL_W'(1)) begin
                        n_fill  = '0;
                        n_cnt   = '0;
                        n_state = r_end ? S_TRL : S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx + FILL_W'(1);
                        n_idx   = r_idx + FILL_W'(1);
                    end
                end
            end
            S_TRL: begin
                o_push.vld  = 1'b1;
                o_push.last = (r_cnt == CNT_W'(TRL_LEN - 1));
                if (r_cnt == CNT_W'(TRL_QTYPE)) begin
                    o_push.data = i_qtype;
                end else if (r_cnt == CNT_W'(TRL_CLASS)) begin
                    o_push.data = CLASS_IN;
                end else begin
                    o_push.data = 8'h00;
                end
                if (i_push_rdy) begin
                    if (o_push.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            S_ERR: begin
                o_push.vld  = 1'b1;
                o_push.err  = 1'b1;
                o_push.last = 1'b1;
                if (i_push_rdy) begin
                    n_fill  = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_fill] <= r_cmd.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_fill  <= '0;
            r_idx   <= '0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
            r_end   <= n_end;
        end
    end

    a_body_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BODY) |-> (r_idx < r_fill))
        else $error("label read beyond fill");
    a_store_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && (r_cmd.op == OP_STORE || r_cmd.op == OP_STORE_END))
        |-> (r_fill < FILL_W'(MAX_LABEL)))
        else $error("label store write past maximum label length");

endmodule
`default_nettype wire

// File: rtl/core/dqb_packer.sv
`default_nettype none
// ============================================================================
// dqb_packer: byte pairing and output register
// Pairs packet bytes into words, closes packets and forms error words.
// ============================================================================
module dqb_packer (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire dqb_pkg::t_push i_push,
    output logic                o_push_rdy,
    output logic                o_valid,
    input  wire logic           i_ready,
    output dqb_pkg::t_word      o_word
);
    import dqb_pkg::*;

    logic       r_held, n_held;
    logic [7:0] r_odd;
    logic       r_ovalid;
    t_word      r_word, n_word;
    logic       out_free, makes_word, take;

    assign out_free   = !r_ovalid || i_ready;
    assign makes_word = r_held || i_push.last || i_push.err;
    assign o_push_rdy = !makes_word || out_free;
    assign take       = i_push.vld && o_push_rdy;
    assign o_valid    = r_ovalid;
    assign o_word     = r_word;

    always_comb begin
        n_held = r_held;
        n_word = '0;
        if (i_push.err) begin
            // drop any half word of the broken packet
            n_word.last = 1'b1;
            n_word.bad  = 1'b1;
            n_held      = 1'b0;
        end else if (r_held) begin
            n_word.first  = r_odd;
            n_word.second = i_push.data;
            n_word.sv     = 1'b1;
            n_word.last   = i_push.last;
            n_held        = 1'b0;
        end else if (i_push.last) begin
            n_word.first = i_push.data;
            n_word.last  = 1'b1;
            n_held       = 1'b0;
        end else begin
            n_held = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && makes_word) begin
            r_word <= n_word;
        end
        if (take && !makes_word) begin
            r_odd <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (take) begin
                r_held <= n_held;
            end
            if (take && makes_word) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    a_err_word_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_word.bad) |-> (r_word.last && !r_word.sv && r_word.first == 8'h00))
        else $error("malformed error word");
    a_err_clears_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (i_push.err || i_push.last)) |=> !r_held)
        else $error("half word survives end of packet");

endmodule
`default_nettype wire

// File: rtl/core/dns_query_builder_top.sv
`default_nettype none
// ============================================================================
// dns_query_builder_top: DNS query packet builder
// Hostname bytes in, query packet out as 16-bit words; APB query type register.
// ============================================================================
// Throughput: the classifier takes one byte a cycle while the 4-entry command
//   queue has room; the sequencer finishes each command before it pops the next,
//   playing the 12-byte header, each length byte and label bytes, the 5-byte tail.
// Reset: synchronous, active low; clears control state and sets query type to 1.
//   The label store is not cleared.
module dns_query_builder_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input stream
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [7:0]                  i_s_tdata,   // [7:0] name_byte
    input  wire logic                        i_s_tlast,   // final_byte
    // output stream
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic [15:0]                      o_m_tdata,   // [7:0] first_byte, [15:8] second_byte
    output logic [1:0]                       o_m_tuser,   // [0] second_valid, [1] bad_name
    output logic                             o_m_tlast,   // packet_end
    // configuration
    input  wire logic                        i_psel,
    input  wire logic                        i_penable,
    input  wire logic                        i_pwrite,
    input  wire logic [dqb_pkg::ADDR_W-1:0]  i_paddr,
    input  wire logic [31:0]                 i_pwdata,
    output logic [31:0]                      o_prdata,
    output logic                             o_pready
);
    import dqb_pkg::*;

    logic [7:0] r_qtype;
    logic       reg_hit;
    logic       q_push, q_full, q_pop, q_empty;
    t_cmd       f_cmd, q_cmd;
    t_push      b_push;
    logic       push_rdy;
    t_word      word;

    // configuration
    assign o_pready = 1'b1;
    assign reg_hit  = (i_paddr[ADDR_W-1:2] == REG_QTYPE);
    assign o_prdata = reg_hit ? {24'h0, r_qtype} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qtype <= QTYPE_RST;
        end else if (i_psel && i_penable && i_pwrite && o_pready && reg_hit) begin
            r_qtype <= i_pwdata[7:0];
        end
    end

    dqb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_byte  (i_s_tdata),
        .i_final (i_s_tlast),
        .o_ready (o_s_tready),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (f_cmd)
    );

    dqb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    dqb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .o_pop      (q_pop),
        .i_cmd      (q_cmd),
        .i_qtype    (r_qtype),
        .o_push     (b_push),
        .i_push_rdy (push_rdy)
    );

    dqb_packer u_packer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (b_push),
        .o_push_rdy (push_rdy),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_word     (word)
    );

    assign o_m_tdata = {word.second, word.first};
    assign o_m_tuser = {word.bad, word.sv};
    assign o_m_tlast = word.last;

endmodule
`default_nettype wire
